// ===== hw/rtl/debounced_quadrature_decoder_core_macros.svh =====
`ifndef DEBOUNCED_QUADRATURE_DECODER_CORE_MACROS_SVH
`define DEBOUNCED_QUADRATURE_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define QDEC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qdec check failed");

// next-cycle implication, checked on clk outside reset
`define QDEC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qdec check failed");

`endif

// ===== hw/rtl/qdec_pkg.sv =====
`timescale 1ns / 1ps

package qdec_pkg;

  localparam int ELAPSED_WIDTH = 24;
  localparam int TICKS_WIDTH   = 24;
  localparam int COUNT_WIDTH   = 32;
  localparam int CMP_WIDTH     = 33;

  localparam logic [TICKS_WIDTH-1:0] DEBOUNCE_RESET = TICKS_WIDTH'(30 * 1000);

  typedef enum logic [2:0] {
    CMD_TICK          = 3'd0,
    CMD_EDGE_A        = 3'd1,
    CMD_EDGE_B        = 3'd2,
    CMD_WRITE_COUNT   = 3'd3,
    CMD_WRITE_CHANGED = 3'd4
  } qdec_cmd_t;

  localparam logic [1:0] EV_B_FALL  = 2'd2;
  localparam logic [1:0] EV_B_RISE  = 2'd3;
  localparam logic [1:0] PHASE_REST = 2'd0;
  localparam logic [1:0] PHASE_LAST = 2'd3;

  typedef struct packed {
    logic [2:0]               command;
    logic                     clk_level;
    logic                     dt_level;
    logic signed [COUNT_WIDTH-1:0] write_value;
  } qdec_in_t;

  typedef struct packed {
    logic signed [COUNT_WIDTH-1:0] position_count;
    logic                     changed;
    logic [1:0]               phase;
    logic                     edge_accepted;
  } qdec_out_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] code;
  } qdec_evt_t;

  localparam logic [1:0] NEXT_PHASE [4][4] = '{
    '{2'd0, 2'd0, 2'd3, 2'd3},
    '{2'd1, 2'd1, 2'd2, 2'd2},
    '{2'd0, 2'd1, 2'd1, 2'd0},
    '{2'd3, 2'd2, 2'd2, 2'd3}
  };

  function automatic logic [1:0] next_phase(logic [1:0] ev, logic [1:0] ph);
    return NEXT_PHASE[ev][ph];
  endfunction

endpackage

// ===== hw/rtl/qdec_debounce.sv =====
`timescale 1ns / 1ps

module qdec_debounce (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  qdec_pkg::qdec_in_t                  item,
  input  logic [qdec_pkg::TICKS_WIDTH-1:0]    ticks,
  output qdec_pkg::qdec_evt_t                 evt
);
  import qdec_pkg::*;

  localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;

  logic [ELAPSED_WIDTH-1:0] elapsed_a;
  logic [ELAPSED_WIDTH-1:0] elapsed_b;
  logic [ELAPSED_WIDTH-1:0] elapsed_a_next;
  logic [ELAPSED_WIDTH-1:0] elapsed_b_next;
  logic                     ok_a;
  logic                     ok_b;

  assign ok_a = CMP_WIDTH'(elapsed_a) > CMP_WIDTH'(ticks);
  assign ok_b = CMP_WIDTH'(elapsed_b) > CMP_WIDTH'(ticks);

  always_comb begin
    elapsed_a_next = elapsed_a;
    elapsed_b_next = elapsed_b;
    evt            = '0;
    unique case (item.command)
      CMD_TICK: begin
        if (elapsed_a != ELAPSED_MAX) elapsed_a_next = elapsed_a + 1'b1;
        if (elapsed_b != ELAPSED_MAX) elapsed_b_next = elapsed_b + 1'b1;
      end
      CMD_EDGE_A: begin
        elapsed_a_next = '0;
        evt.accepted   = ok_a;
        evt.code       = {1'b0, item.clk_level};
      end
      CMD_EDGE_B: begin
        elapsed_b_next = '0;
        evt.accepted   = ok_b;
        evt.code       = {1'b1, item.dt_level};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_a <= '0;
      elapsed_b <= '0;
    end else if (advance) begin
      elapsed_a <= elapsed_a_next;
      elapsed_b <= elapsed_b_next;
    end
  end

endmodule

// ===== hw/rtl/qdec_phase.sv =====
`timescale 1ns / 1ps

module qdec_phase (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  qdec_pkg::qdec_in_t   item,
  input  qdec_pkg::qdec_evt_t  evt,
  output qdec_pkg::qdec_out_t  res
);
  import qdec_pkg::*;

  logic [1:0]             phase;
  logic [COUNT_WIDTH-1:0] count;
  logic                   changed;
  logic [1:0]             phase_next;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   changed_next;

  always_comb begin
    phase_next   = phase;
    count_next   = count;
    changed_next = changed;
    unique case (item.command)
      CMD_WRITE_COUNT:   count_next   = item.write_value;
      CMD_WRITE_CHANGED: changed_next = item.write_value[0];
      default: begin
        if (evt.accepted) begin
          if (phase == PHASE_REST && evt.code == EV_B_RISE) begin
            count_next   = count - 1'b1;
            changed_next = 1'b1;
          end else if (phase == PHASE_LAST && evt.code == EV_B_FALL) begin
            count_next   = count + 1'b1;
            changed_next = 1'b1;
          end
          phase_next = next_phase(evt.code, phase);
        end
      end
    endcase
  end

  assign res.position_count = count_next;
  assign res.changed        = changed_next;
  assign res.phase          = phase_next;
  assign res.edge_accepted  = evt.accepted;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PHASE_REST;
      count   <= '0;
      changed <= 1'b0;
    end else if (advance) begin
      phase   <= phase_next;
      count   <= count_next;
      changed <= changed_next;
    end
  end

endmodule

// ===== hw/rtl/debounced_quadrature_decoder_core.sv =====
`timescale 1ns / 1ps
// channel  direction  handshake               payload
// in       sink       in_valid / in_ready     in_data  (qdec_in_t)
// out      source     out_valid / out_ready   out_data (qdec_out_t)
// cfg      sink       cfg_write_en            cfg_write_data (debounce ticks)
//
// One item per clock while out_ready holds; an accepted item passes through
// the input register, then the result register, to reach out_data.
// State updates in the single step between those two registers.
// Reset clears valid flags and decoder state; loads debounce ticks with 30000.
// A stalled output holds its item; the input register still takes one more.

`include "debounced_quadrature_decoder_core_macros.svh"

module debounced_quadrature_decoder_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  qdec_pkg::qdec_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output qdec_pkg::qdec_out_t              out_data,
  input  logic                             cfg_write_en,
  input  logic [qdec_pkg::TICKS_WIDTH-1:0] cfg_write_data
);
  import qdec_pkg::*;

  logic [TICKS_WIDTH-1:0] debounce_ticks;
  logic                   s1_valid;
  qdec_in_t               s1_item;
  logic                   advance;
  qdec_evt_t              evt;
  qdec_out_t              res;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg_write_en) begin
      debounce_ticks <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
  end

  qdec_debounce u_debounce (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .ticks   (debounce_ticks),
    .evt     (evt)
  );

  qdec_phase u_phase (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .evt     (evt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  `QDEC_ASSERT_NOW(a_accept_only_edges, advance && res.edge_accepted,
    s1_item.command == CMD_EDGE_A || s1_item.command == CMD_EDGE_B)
  `QDEC_ASSERT_NEXT(a_hold_stalled_item, s1_valid && !advance,
    s1_valid && $stable(s1_item))
  `QDEC_ASSERT_NOW(a_ready_when_drained, out_ready, in_ready)

endmodule
